// File: hdl/murmur3_32_hash_macros.svh
// assertion macros for the murmur3 hash block
`ifndef MURMUR3_32_HASH_MACROS_SVH
`define MURMUR3_32_HASH_MACROS_SVH

// same-cycle implication, checked outside reset
`define MM3_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MM3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/mm3_pkg.sv
// shared constants and types for the murmur3 hash block
`timescale 1ns / 1ps

package mm3_pkg;

    localparam logic [31:0] MIX_C1     = 32'hCC9E2D51;
    localparam logic [31:0] MIX_C2     = 32'h1B873593;
    localparam logic [31:0] MIX_ADD    = 32'hE6546B64;
    localparam logic [31:0] FIN_C1     = 32'h85EBCA6B;
    localparam logic [31:0] FIN_C2     = 32'hC2B2AE35;
    localparam logic [31:0] SEED_RESET = 32'h3B9ACA07;

    localparam logic [2:0] FULL_COUNT = 3'd4;
    localparam int QUEUE_DEPTH = 4;

    // one word-mixed item on its way to the state mix
    typedef struct packed {
        logic [31:0] k;
        logic [2:0]  cnt;
        logic        fin;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: hdl/mm3_ifs.sv
// handshake channels of the murmur3 hash block
`timescale 1ns / 1ps

interface mm3_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;
    logic [2:0]  byte_count;
    logic        last;
    modport source (output valid, output word, output byte_count, output last, input ready);
    modport sink (input valid, input word, input byte_count, input last, output ready);
endinterface

interface mm3_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash;
    modport source (output valid, output hash, input ready);
    modport sink (input valid, input hash, output ready);
endinterface

interface mm3_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/mm3_front.sv
// front end: takes items, classifies them and runs the word mix
`timescale 1ns / 1ps

module mm3_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mm3_in_if.sink         i_in,
    input  logic           i_q_full,
    output logic           o_push,
    output mm3_pkg::t_work o_work
);

    logic        r_v1;
    logic        r_v2;
    logic [31:0] r_k1;
    logic [31:0] r_k2;
    logic [2:0]  r_cnt1;
    logic [2:0]  r_cnt2;
    logic        r_fin1;
    logic        r_fin2;

    logic        en;
    logic [2:0]  cnt;
    logic        fin;
    logic [31:0] masked;
    logic [31:0] rot;

    assign en = !r_v2 || !i_q_full;
    assign i_in.ready = en;

    always_comb begin
        cnt = (i_in.byte_count > mm3_pkg::FULL_COUNT) ? mm3_pkg::FULL_COUNT
                                                      : i_in.byte_count;
        // a short word always closes the message
        fin = i_in.last || (cnt != mm3_pkg::FULL_COUNT);
        case (cnt)
            3'd0:    masked = 32'h0;
            3'd1:    masked = {24'h0, i_in.word[7:0]};
            3'd2:    masked = {16'h0, i_in.word[15:0]};
            3'd3:    masked = {8'h0, i_in.word[23:0]};
            default: masked = i_in.word;
        endcase
        rot = {r_k1[16:0], r_k1[31:17]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_k1   <= masked * mm3_pkg::MIX_C1;
            r_cnt1 <= cnt;
            r_fin1 <= fin;
            r_k2   <= rot * mm3_pkg::MIX_C2;
            r_cnt2 <= r_cnt1;
            r_fin2 <= r_fin1;
        end
    end

    assign o_push     = r_v2 && !i_q_full;
    assign o_work.k   = r_k2;
    assign o_work.cnt = r_cnt2;
    assign o_work.fin = r_fin2;

endmodule

// File: hdl/mm3_queue.sv
// short queue between the word mix and the state mix
`timescale 1ns / 1ps

module mm3_queue #(
    parameter int DEPTH = mm3_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  mm3_pkg::t_work             i_work,
    input  logic                       i_pop,
    output mm3_pkg::t_work             o_work,
    output mm3_pkg::t_q_stat           o_stat,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mm3_pkg::t_work r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_work       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_count      = r_count;

endmodule

// File: hdl/mm3_back.sv
// back end: state mix, length count and final avalanche
`timescale 1ns / 1ps

module mm3_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [31:0]      i_seed,
    input  mm3_pkg::t_work   i_work,
    input  mm3_pkg::t_q_stat i_stat,
    output logic             o_pop,
    mm3_out_if.source        o_out
);

    logic        r_open;
    logic [31:0] r_hash;
    logic [31:0] r_len;
    logic        r_v0;
    logic        r_v1;
    logic        r_v2;
    logic        r_ov;
    logic [31:0] r_f0;
    logic [31:0] r_m1;
    logic [31:0] r_m2;
    logic [31:0] r_out;

    logic        en;
    logic [31:0] h0;
    logic [31:0] len1;
    logic [31:0] x;
    logic [31:0] rot;
    logic [31:0] h1;
    logic [31:0] a;
    logic [31:0] b;

    assign en    = !r_ov || o_out.ready;
    assign o_pop = !i_stat.empty && en;

    always_comb begin
        h0   = r_open ? r_hash : i_seed;
        len1 = (r_open ? r_len : 32'h0) + {29'h0, i_work.cnt};
        x    = h0 ^ i_work.k;
        rot  = {x[18:0], x[31:19]};
        // tail bytes only xor in, a full word runs the whole state mix
        h1   = (i_work.cnt == mm3_pkg::FULL_COUNT)
             ? ({rot[29:0], 2'b00} + rot + mm3_pkg::MIX_ADD) : x;
        a    = r_f0 ^ {16'h0, r_f0[31:16]};
        b    = r_m1 ^ {13'h0, r_m1[31:13]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_open <= !i_work.fin;
            end
            if (en) begin
                r_v0 <= o_pop && i_work.fin;
                r_v1 <= r_v0;
                r_v2 <= r_v1;
                r_ov <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hash <= h1;
            r_len  <= len1;
        end
        if (en) begin
            r_f0  <= h1 ^ len1;
            r_m1  <= a * mm3_pkg::FIN_C1;
            r_m2  <= b * mm3_pkg::FIN_C2;
            r_out <= r_m2 ^ {16'h0, r_m2[31:16]};
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.hash  = r_out;

endmodule

// File: hdl/murmur3_32_hash.sv
// MurmurHash3 x86_32 streaming hash, top level
//
// i_in carries one message word per item: word (first byte in bits 7:0),
// byte_count (0 to 4, higher counts count as 4) and last. A word with
// fewer than four bytes, or with last set, closes the message. One hash
// per message leaves on o_out. i_cfg writes the seed, which is taken when
// the first item of the next message reaches the state mix; it is always
// ready and should be written only while the block is idle.
// Throughput: one item per cycle. The front runs the word mix in two
// multiply stages, a small queue follows, and the back folds one item per
// cycle into the running state and finalizes through two more multiply
// stages. When o_out stalls, the back holds and the queue fills;
// i_in.ready drops once the queue is full and the second front stage
// holds an item. Reset empties all stages, closes any open message and
// sets the seed to 0x3B9ACA07.
`timescale 1ns / 1ps
`include "murmur3_32_hash_macros.svh"

module murmur3_32_hash #(
    parameter int QUEUE_DEPTH = mm3_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mm3_in_if.sink     i_in,
    mm3_cfg_if.sink    i_cfg,
    mm3_out_if.source  o_out
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [31:0]      r_seed;
    logic             q_push;
    logic             q_pop;
    mm3_pkg::t_work   push_work;
    mm3_pkg::t_work   pop_work;
    mm3_pkg::t_q_stat q_stat;
    logic [CW-1:0]    q_count;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= mm3_pkg::SEED_RESET;
        end else if (i_cfg.valid) begin
            r_seed <= i_cfg.data;
        end
    end

    mm3_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_stat.full),
        .o_push   (q_push),
        .o_work   (push_work)
    );

    mm3_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_work  (push_work),
        .i_pop   (q_pop),
        .o_work  (pop_work),
        .o_stat  (q_stat),
        .o_count (q_count)
    );

    mm3_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seed  (r_seed),
        .i_work  (pop_work),
        .i_stat  (q_stat),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

    `MM3_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, q_pop, q_count != '0, "pop from empty queue")
    `MM3_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, !i_in.ready, q_stat.full, "input stalled with queue room")
    `MM3_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, q_push && !q_pop, q_count == CW'($past(q_count) + 1'b1), "queue count missed a push")

endmodule
